// ===== sv/rleb_pkg.sv =====
// shared types, codes and constants of the run-length image blitter
package rleb_pkg;

    // default sizes
    localparam int FB_BYTES_DEF  = 32768;
    localparam int MAX_PITCH_DEF = 256;

    // command modes
    localparam logic [1:0] MODE_BEGIN = 2'd0;
    localparam logic [1:0] MODE_CODE  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_WRITE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_FB_PITCH    = 2'd0;
    localparam logic [1:0] REG_DEST_BASE   = 2'd1;
    localparam logic [1:0] REG_IMAGE_PAIRS = 2'd2;
    localparam logic [1:0] REG_IMAGE_ROWS  = 2'd3;

    // configuration reset values
    localparam logic [8:0]  FB_PITCH_RST    = 9'd160;
    localparam logic [14:0] DEST_BASE_RST   = 15'd0;
    localparam logic [8:0]  IMAGE_PAIRS_RST = 9'd1;
    localparam logic [9:0]  IMAGE_ROWS_RST  = 10'd1;

    // result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // stream codes and pixel masks
    localparam logic [7:0] END_MARK  = 8'd62;
    localparam logic [7:0] WHITE_HI  = 8'h38;
    localparam logic [7:0] WHITE_LO  = 8'h07;
    localparam int         FLAG_HI_B = 7;
    localparam int         FLAG_LO_B = 6;

    localparam int CFG_DATA_W = 15;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  code_byte;
        logic [14:0] address;
        logic [7:0]  write_data;
    } cmd_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] read_data;
        logic       ended_early;
    } result_t;

    // one emitted value headed for read-modify-write
    typedef struct packed {
        logic       vld;
        logic [7:0] value;
    } emit_t;

    // composite a value into a framebuffer byte
    function automatic logic [7:0] composite(input logic [7:0] old_byte,
                                             input logic [7:0] value);
        logic [7:0] b;
        b = old_byte;
        if (value[FLAG_HI_B])
        begin
            b = b | WHITE_HI;
        end
        if (value[FLAG_LO_B])
        begin
            b = b | WHITE_LO;
        end
        return b & value;
    endfunction

endpackage

// ===== sv/rle_image_blitter.sv =====
// top level: command sequencer, run-length decoder, rectangle walker and framebuffer
//
//  channel   signals                               transfer when
//  command   start, busy, cmd                      start && !busy
//  config    cfg_valid, cfg_ready, cfg_index,      cfg_valid && cfg_ready
//            cfg_data
//  result    result_valid, result                  result_valid (one cycle)
//
// a literal code byte is read in the accept cycle, then composited and written in the next.
// a run of n emissions walks the framebuffer one byte per cycle through
// the single read and single write port, with the write-back forwarded to the next read.
// a host read passes through the registered ram read and the ST_READ state.
// reset is asynchronous active low; the framebuffer itself is not cleared.
// results are registered from the work that produced them and cannot be held off.
// config writes are held off by cfg_ready while the block is busy.
module rle_image_blitter #(
    parameter int FB_BYTES  = rleb_pkg::FB_BYTES_DEF,
    parameter int MAX_PITCH = rleb_pkg::MAX_PITCH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  rleb_pkg::cmd_t                      cmd,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [rleb_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                result_valid,
    output rleb_pkg::result_t                   result
);
    import rleb_pkg::*;

    localparam int AW   = $clog2(FB_BYTES);
    localparam int RA_W = $clog2(FB_BYTES + 1);
    localparam int PW   = $clog2(MAX_PITCH + 1);
    localparam int M1   = (RA_W > 15) ? RA_W : 15;
    localparam int M2   = (PW > 9) ? PW : 9;
    localparam int WW   = ((M1 > M2) ? M1 : M2) + 1;

    localparam logic [WW-1:0] FB_LIM    = WW'(FB_BYTES);
    localparam logic [WW-1:0] PITCH_LIM = WW'(MAX_PITCH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    // control and configuration registers
    logic [1:0]      state_reg, state_next;
    logic [8:0]      pitch_reg, pitch_next;
    logic [14:0]     base_reg, base_next;
    logic [8:0]      pairs_reg, pairs_next;
    logic [9:0]      rows_reg, rows_next;
    logic [7:0]      last_reg, last_next;
    logic [7:0]      high_reg, high_next;
    logic            await_reg, await_next;
    logic [8:0]      col_reg, col_next;
    logic [9:0]      row_reg, row_next;
    logic [RA_W-1:0] ra_reg, ra_next;
    logic            fin_reg, fin_next;
    logic [16:0]     cnt_reg, cnt_next;
    logic            rd_oob_reg, rd_oob_next;
    logic            res_vld_reg, res_vld_next;
    result_t         res_reg, res_next;

    // datapath signals
    logic            accept;
    logic            code_emit;
    logic            is_lit;
    logic            emit;
    logic [7:0]      emit_val;
    logic [15:0]     n16;
    logic [16:0]     n_total;
    logic [16:0]     remaining;
    logic [WW-1:0]   addr_w;
    logic            addr_ok;
    logic [8:0]      col_inc;
    logic [9:0]      row_inc;
    logic            row_end;
    logic            full;
    logic            end_mark;
    logic [WW-1:0]   pitch_w;
    logic [WW-1:0]   ra_sum;
    logic [WW-1:0]   base_w;
    logic [WW-1:0]   host_w;
    logic            host_ok;
    logic            host_rd;
    logic            host_wr;

    // ram and write-back wiring
    emit_t           issue;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;
    logic            wb_en;
    logic [AW-1:0]   wb_addr;
    logic [7:0]      wb_data;
    logic            wb_pending;

    assign busy      = (state_reg != ST_IDLE) || wb_pending;
    assign cfg_ready = !busy;
    assign accept    = start && !busy;

    // command decode
    always_comb
    begin
        is_lit    = !await_reg && (cmd.code_byte >= END_MARK);
        code_emit = accept && (cmd.mode == MODE_CODE) && !fin_reg
                    && (await_reg || (cmd.code_byte >= END_MARK));
        emit      = code_emit || (state_reg == ST_RUN);
        emit_val  = (code_emit && is_lit) ? cmd.code_byte : last_reg;
        n16       = {high_reg, cmd.code_byte};
        if (is_lit)
        begin
            n_total = 17'd1;
        end
        else if (n16 == 16'd0)
        begin
            n_total = 17'h10000;
        end
        else
        begin
            n_total = {1'b0, n16};
        end
        remaining = (code_emit ? n_total : cnt_reg) - 17'd1;
        end_mark  = code_emit && is_lit && (cmd.code_byte == END_MARK);
        host_w    = WW'(cmd.address);
        host_ok   = host_w < FB_LIM;
        host_rd   = accept && (cmd.mode == MODE_READ);
        host_wr   = accept && (cmd.mode == MODE_WRITE) && host_ok;
        base_w    = WW'(base_reg);
    end

    // rectangle walker for one emission
    always_comb
    begin
        addr_w  = WW'(ra_reg) + WW'(col_reg);
        addr_ok = addr_w < FB_LIM;
        col_inc = col_reg + 9'd1;
        row_inc = row_reg + 10'd1;
        row_end = col_inc == pairs_reg;
        full    = row_end && (row_inc == rows_reg);
        pitch_w = (WW'(pitch_reg) > PITCH_LIM) ? PITCH_LIM : WW'(pitch_reg);
        ra_sum  = WW'(ra_reg) + pitch_w;
    end

    // sequencer and decoder state
    always_comb
    begin
        state_next   = state_reg;
        pitch_next   = pitch_reg;
        base_next    = base_reg;
        pairs_next   = pairs_reg;
        rows_next    = rows_reg;
        last_next    = last_reg;
        high_next    = high_reg;
        await_next   = await_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        ra_next      = ra_reg;
        fin_next     = fin_reg;
        cnt_next     = cnt_reg;
        rd_oob_next  = rd_oob_reg;
        res_vld_next = 1'b0;
        res_next     = res_reg;

        // configuration transaction
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FB_PITCH:    pitch_next = cfg_data[8:0];
                REG_DEST_BASE:   base_next  = cfg_data[14:0];
                REG_IMAGE_PAIRS: pairs_next = cfg_data[8:0];
                REG_IMAGE_ROWS:  rows_next  = cfg_data[9:0];
                default:         pitch_next = pitch_reg;
            endcase
        end

        // command transaction
        if (accept)
        begin
            unique case (cmd.mode)
                MODE_BEGIN:
                begin
                    last_next  = 8'd0;
                    high_next  = 8'd0;
                    await_next = 1'b0;
                    col_next   = 9'd0;
                    row_next   = 10'd0;
                    ra_next    = RA_W'((base_w > FB_LIM) ? FB_LIM : base_w);
                    fin_next   = 1'b0;
                end
                MODE_READ:
                begin
                    state_next  = ST_READ;
                    rd_oob_next = !host_ok;
                end
                MODE_WRITE:
                begin
                    state_next = ST_IDLE;
                end
                MODE_CODE:
                begin
                    if (!fin_reg)
                    begin
                        if (await_reg)
                        begin
                            await_next = 1'b0;
                        end
                        else if (cmd.code_byte < END_MARK)
                        begin
                            high_next  = cmd.code_byte;
                            await_next = 1'b1;
                        end
                        else
                        begin
                            last_next = cmd.code_byte;
                        end
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end

        // one emission walks the rectangle
        if (emit)
        begin
            if (row_end)
            begin
                col_next = 9'd0;
                row_next = row_inc;
                ra_next  = RA_W'((ra_sum > FB_LIM) ? FB_LIM : ra_sum);
            end
            else
            begin
                col_next = col_inc;
            end
            if (full || end_mark)
            begin
                fin_next              = 1'b1;
                state_next            = ST_IDLE;
                res_vld_next          = 1'b1;
                res_next.result_kind  = KIND_DONE;
                res_next.read_data    = 8'd0;
                res_next.ended_early  = !full;
            end
            else if (remaining == 17'd0)
            begin
                state_next = ST_IDLE;
            end
            else
            begin
                state_next = ST_RUN;
                cnt_next   = remaining;
            end
        end

        // host read answer
        if (state_reg == ST_READ)
        begin
            state_next           = ST_IDLE;
            res_vld_next         = 1'b1;
            res_next.result_kind = KIND_READ;
            res_next.read_data   = rd_oob_reg ? 8'd0 : ram_rdata;
            res_next.ended_early = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pitch_reg   <= FB_PITCH_RST;
            base_reg    <= DEST_BASE_RST;
            pairs_reg   <= IMAGE_PAIRS_RST;
            rows_reg    <= IMAGE_ROWS_RST;
            last_reg    <= 8'd0;
            high_reg    <= 8'd0;
            await_reg   <= 1'b0;
            col_reg     <= 9'd0;
            row_reg     <= 10'd0;
            ra_reg      <= '0;
            fin_reg     <= 1'b1;
            cnt_reg     <= 17'd0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pitch_reg   <= pitch_next;
            base_reg    <= base_next;
            pairs_reg   <= pairs_next;
            rows_reg    <= rows_next;
            last_reg    <= last_next;
            high_reg    <= high_next;
            await_reg   <= await_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            ra_reg      <= ra_next;
            fin_reg     <= fin_next;
            cnt_reg     <= cnt_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        rd_oob_reg <= rd_oob_next;
        res_reg    <= res_next;
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    // framebuffer port selection
    always_comb
    begin
        issue.vld   = emit && addr_ok;
        issue.value = emit_val;
        ram_re      = emit || host_rd;
        ram_raddr   = host_rd ? AW'(host_w) : AW'(addr_w);
        ram_we      = wb_en || host_wr;
        ram_waddr   = wb_en ? wb_addr : AW'(host_w);
        ram_wdata   = wb_en ? wb_data : cmd.write_data;
    end

    rleb_wb #(
        .AW (AW)
    ) u_wb (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .issue_addr (AW'(addr_w)),
        .rdata      (ram_rdata),
        .wr_en      (wb_en),
        .wr_addr    (wb_addr),
        .wr_data    (wb_data),
        .pending    (wb_pending)
    );

    rleb_ram #(
        .WIDTH (8),
        .DEPTH (FB_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== sv/rleb_ram.sv =====
// generic single-port-write, registered-read synchronous ram
module rleb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/rleb_wb.sv =====
// write-back stage: composites read data with the emitted value, forwards its own last write
module rleb_wb #(
    parameter int AW = 15
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rleb_pkg::emit_t issue,
    input  logic [AW-1:0]   issue_addr,
    input  logic [7:0]      rdata,
    output logic            wr_en,
    output logic [AW-1:0]   wr_addr,
    output logic [7:0]      wr_data,
    output logic            pending
);
    import rleb_pkg::*;

    logic          vld_reg;
    logic [AW-1:0] addr_reg;
    logic [7:0]    val_reg;
    logic          fwd_vld_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [7:0]    fwd_data_reg;
    logic [7:0]    old_byte;
    logic [7:0]    merged;

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= 1'b0;
            fwd_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= issue.vld;
            fwd_vld_reg <= vld_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        addr_reg     <= issue_addr;
        val_reg      <= issue.value;
        fwd_addr_reg <= addr_reg;
        fwd_data_reg <= merged;
    end

    // the write of the previous cycle is not yet visible in the read data
    always_comb
    begin
        old_byte = (fwd_vld_reg && (fwd_addr_reg == addr_reg)) ? fwd_data_reg : rdata;
        merged   = composite(old_byte, val_reg);
    end

    assign wr_en   = vld_reg;
    assign wr_addr = addr_reg;
    assign wr_data = merged;
    assign pending = vld_reg;

endmodule

// ===== verif/rle_image_blitter_tb.sv =====
// testbench for the run-length image blitter: directed and random streams checked against a predictor
module rle_image_blitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rleb_pkg::*;

    localparam int ITEM_TARGET    = 1900;
    localparam int WATCHDOG_LIMIT = 200000;

    // predicts framebuffer contents and results, checks them in order
    class blit_scoreboard;
        logic [7:0]  frame_mem [0:FB_BYTES_DEF-1];
        bit          known [0:FB_BYTES_DEF-1];
        logic [8:0]  pitch_reg;
        logic [14:0] base_reg;
        logic [8:0]  pairs_reg;
        logic [9:0]  rows_reg;
        logic [7:0]  last_val;
        logic [7:0]  run_high;
        bit          wait_low;
        logic [8:0]  col;
        logic [9:0]  row_cnt;
        logic [15:0] row_addr;
        bit          idle;
        bit          early;
        result_t     expected_q[$];
        int unsigned mismatches;

        function new();
            pitch_reg  = FB_PITCH_RST;
            base_reg   = DEST_BASE_RST;
            pairs_reg  = IMAGE_PAIRS_RST;
            rows_reg   = IMAGE_ROWS_RST;
            last_val   = '0;
            run_high   = '0;
            wait_low   = 1'b0;
            col        = '0;
            row_cnt    = '0;
            row_addr   = '0;
            idle       = 1'b1;
            early      = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FB_PITCH:    pitch_reg = data[8:0];
                REG_DEST_BASE:   base_reg  = data[14:0];
                REG_IMAGE_PAIRS: pairs_reg = data[8:0];
                REG_IMAGE_ROWS:  rows_reg  = data[9:0];
                default: ;
            endcase
        endfunction

        // blend one value into the next rectangle byte; returns 1 when the rectangle is full
        function bit draw_pair(logic [7:0] value);
            logic [16:0] addr;
            logic [16:0] next_row;
            logic [8:0]  step;
            logic [7:0]  b;
            addr = row_addr + col;
            step = (pitch_reg > MAX_PITCH_DEF) ? 9'(MAX_PITCH_DEF) : pitch_reg;
            if (addr < FB_BYTES_DEF)
            begin
                b = frame_mem[addr];
                if (value[FLAG_HI_B])
                begin
                    b = b | WHITE_HI;
                end
                if (value[FLAG_LO_B])
                begin
                    b = b | WHITE_LO;
                end
                frame_mem[addr] = b & value;
            end
            col = col + 9'd1;
            if (col == pairs_reg)
            begin
                col      = '0;
                row_cnt  = row_cnt + 10'd1;
                next_row = row_addr + step;
                row_addr = (next_row > FB_BYTES_DEF) ? 16'(FB_BYTES_DEF) : next_row[15:0];
                if (row_cnt == rows_reg)
                begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // update the prediction for one accepted command transaction
        function void note_command(cmd_t c);
            result_t     e;
            bit          done;
            int unsigned span;
            int unsigned k;
            done = 1'b0;
            if (c.mode == MODE_BEGIN)
            begin
                last_val = '0;
                run_high = '0;
                wait_low = 1'b0;
                col      = '0;
                row_cnt  = '0;
                row_addr = {1'b0, base_reg};
                idle     = 1'b0;
                early    = 1'b0;
            end
            else if (c.mode == MODE_READ)
            begin
                e.result_kind = KIND_READ;
                e.read_data   = frame_mem[c.address];
                e.ended_early = 1'b0;
                expected_q.push_back(e);
            end
            else if (c.mode == MODE_WRITE)
            begin
                frame_mem[c.address] = c.write_data;
                known[c.address]     = 1'b1;
            end
            else if (!idle)
            begin
                if (wait_low)
                begin
                    wait_low = 1'b0;
                    span = {run_high, c.code_byte};
                    if (span == 0)
                    begin
                        span = 65536;
                    end
                    for (k = 0; k < span && !done; k++)
                    begin
                        done = draw_pair(last_val);
                    end
                end
                else if (c.code_byte < END_MARK)
                begin
                    run_high = c.code_byte;
                    wait_low = 1'b1;
                end
                else
                begin
                    last_val = c.code_byte;
                    done = draw_pair(c.code_byte);
                    if (c.code_byte == END_MARK && !done)
                    begin
                        done  = 1'b1;
                        early = 1'b1;
                    end
                end
                if (done)
                begin
                    idle = 1'b1;
                    e.result_kind = KIND_DONE;
                    e.read_data   = '0;
                    e.ended_early = early;
                    expected_q.push_back(e);
                end
            end
        endfunction

        function void check_result(result_t r);
            result_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: result_kind %0d read_data %0h ended_early %0d",
                       r.result_kind, r.read_data, r.ended_early);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            if (r.result_kind !== e.result_kind)
            begin
                $error("result_kind: expected %0d, got %0d", e.result_kind, r.result_kind);
                mismatches++;
            end
            if (r.read_data !== e.read_data)
            begin
                $error("read_data: expected %0h, got %0h", e.read_data, r.read_data);
                mismatches++;
            end
            if (r.ended_early !== e.ended_early)
            begin
                $error("ended_early: expected %0d, got %0d", e.ended_early, r.ended_early);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    cmd_t                  cmd;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  result_valid;
    result_t               result;

    blit_scoreboard sb = new();
    int unsigned    item_count;
    int unsigned    burst_left;
    int unsigned    quiet_cycles;

    rle_image_blitter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // result checking and watchdog
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            sb.check_result(result);
        end
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[rle_image_blitter] ERROR");
            $finish;
        end
    end

    // present one command and hold it until the transaction completes; start stays high
    task automatic send_cmd(input cmd_t c);
        bit ignored;
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        ignored = (c.mode == MODE_CODE) && sb.idle;
        sb.note_command(c);
        if (!ignored)
        begin
            item_count++;
        end
    endtask

    // sender bursts with random gaps in between
    task automatic pace();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                      : $urandom_range(0, 12);
        end
    endtask

    task automatic issue(input cmd_t c);
        send_cmd(c);
        pace();
    endtask

    task automatic do_begin();
        cmd_t c;
        c = cmd_t'({$urandom, $urandom});
        c.mode = MODE_BEGIN;
        issue(c);
    endtask

    task automatic do_code(input logic [7:0] b);
        cmd_t c;
        c = cmd_t'({$urandom, $urandom});
        c.mode      = MODE_CODE;
        c.code_byte = b;
        issue(c);
    endtask

    task automatic do_read(input logic [14:0] a);
        cmd_t c;
        c = cmd_t'({$urandom, $urandom});
        c.mode    = MODE_READ;
        c.address = a;
        issue(c);
    endtask

    task automatic do_write(input logic [14:0] a, input logic [7:0] d);
        cmd_t c;
        c = cmd_t'({$urandom, $urandom});
        c.mode       = MODE_WRITE;
        c.address    = a;
        c.write_data = d;
        issue(c);
    endtask

    // wait until every expected result is in and the block has gone idle
    task automatic drain();
        start <= 1'b0;
        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // write all four registers back to back
    task automatic write_regs(input logic [8:0] pitch, input logic [14:0] base,
                              input logic [8:0] pairs, input logic [9:0] rows);
        logic [1:0]            idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        idx = '{REG_FB_PITCH, REG_DEST_BASE, REG_IMAGE_PAIRS, REG_IMAGE_ROWS};
        val = '{CFG_DATA_W'(pitch), base, CFG_DATA_W'(pairs), CFG_DATA_W'(rows)};
        foreach (idx[i])
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            sb.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // host access, half of the time near the rectangle base so blended bytes get read back;
    // a byte that was never written is written instead of read
    task automatic host_op();
        int          pick;
        logic [14:0] a;
        pick = $urandom_range(0, 9);
        if (pick < 5)
        begin
            a = 15'(sb.base_reg + $urandom_range(0, 1023));
        end
        else
        begin
            a = 15'($urandom);
        end
        if (pick < 8 && sb.known[a])
        begin
            do_read(a);
        end
        else
        begin
            do_write(a, 8'($urandom));
        end
    endtask

    // one image: well-formed stream of literals and runs with host traffic mixed in
    task automatic draw_image();
        int         budget;
        int         codes;
        int         pick;
        int         pe;
        int         re;
        logic [7:0] hi;
        pe = (sb.pairs_reg == 0) ? 512 : sb.pairs_reg;
        re = (sb.rows_reg == 0) ? 1024 : sb.rows_reg;
        budget = (pe * re <= 1100) ? 2000 : $urandom_range(3, 25);
        codes = 0;
        do_begin();
        while (!sb.idle)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                host_op();
            end
            else if (pick < 9)
            begin
                do_begin();
            end
            else if (codes >= budget || pick < 11)
            begin
                do_code(END_MARK);
            end
            else if (pick < 60)
            begin
                do_code(8'($urandom_range(END_MARK + 1, 255)));
            end
            else
            begin
                hi = ($urandom_range(0, 49) == 0) ? 8'($urandom_range(1, END_MARK - 1)) : 8'd0;
                do_code(hi);
                if ($urandom_range(0, 9) == 0)
                begin
                    host_op();
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    do_code(8'($urandom_range(1, 255)));
                end
                else
                begin
                    do_code(8'($urandom_range(1, 24)));
                end
            end
            codes++;
            // occasional full stop of the sender mid-image
            if ($urandom_range(0, 199) == 0)
            begin
                drain();
            end
        end
    endtask

    // stimulus
    initial
    begin
        logic [8:0]  pitch;
        logic [14:0] base;
        logic [8:0]  pairs;
        logic [9:0]  rows;
        int          phase;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        cmd       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        item_count   = 0;
        burst_left   = 0;
        quiet_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset configuration, idle code byte, store extremes
        do_code(8'hFF);
        do_write(15'h7FFF, 8'hFF);
        do_read(15'h7FFF);
        do_write(15'h0000, 8'h5A);
        do_read(15'h0000);
        do_begin();
        do_code(8'hC0);
        do_read(15'h0000);
        do_begin();
        do_code(END_MARK);
        drain();

        // directed: saturated pitch, both flag bits alone, early end, run of 65536
        write_regs(9'd257, 15'd100, 9'd4, 10'd2);
        // known contents under the directed rectangle
        for (int a = 0; a < 4; a++)
        begin
            do_write(15'(100 + a), 8'($urandom));
            do_write(15'(356 + a), 8'($urandom));
        end
        do_begin();
        do_code(8'h80);
        do_code(8'h40);
        do_code(8'd0);
        do_code(8'd3);
        do_code(END_MARK);
        do_begin();
        do_code(8'd0);
        do_code(8'd0);
        do_code(8'h10);
        do_begin();
        do_code(8'd61);
        do_code(8'd255);
        do_read(15'd100);
        do_read(15'd356);
        drain();

        // random phases, extreme settings first
        item_count = 0;
        phase = 0;
        while (item_count < ITEM_TARGET)
        begin
            case (phase)
                0: {pitch, base, pairs, rows} = {9'd1,   15'd0,     9'd1,   10'd0};
                1: {pitch, base, pairs, rows} = {9'd256, 15'd32767, 9'd3,   10'd4};
                2: {pitch, base, pairs, rows} = {9'd511, 15'd32000, 9'd2,   10'd5};
                3: {pitch, base, pairs, rows} = {9'd160, 15'd0,     9'd0,   10'd1};
                4: {pitch, base, pairs, rows} = {9'd256, 15'd0,     9'd256, 10'd512};
                5: {pitch, base, pairs, rows} = {9'd1,   15'd12345, 9'd8,   10'd3};
                6: {pitch, base, pairs, rows} = {9'd40,  15'd20000, 9'd0,   10'd0};
                default:
                begin
                    pitch = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(257, 511))
                                                         : 9'($urandom_range(1, 64));
                    base  = 15'($urandom);
                    pairs = 9'($urandom_range(1, 12));
                    rows  = 10'($urandom_range(1, 8));
                end
            endcase
            drain();
            write_regs(pitch, base, pairs, rows);
            repeat ($urandom_range(2, 5))
            begin
                if (item_count < ITEM_TARGET)
                begin
                    draw_image();
                    if ($urandom_range(0, 6) == 0)
                    begin
                        do_code(8'($urandom));
                    end
                end
            end
            phase++;
        end

        // wind down
        drain();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
        begin
            $display("[rle_image_blitter] OK");
        end
        else
        begin
            $display("[rle_image_blitter] ERROR");
        end
        $finish;
    end

endmodule

// ===== rle_image_blitter.f =====
sv/rleb_pkg.sv
sv/rleb_ram.sv
sv/rleb_wb.sv
sv/rle_image_blitter.sv
verif/rle_image_blitter_tb.sv
